FILE: hw/rtl/damped_spring_force_assert.svh
// ---------------------------------------------------------------------------
// Damped spring force assertion macros
// Concurrent assertion forms used by the spring force direction divider.
// ---------------------------------------------------------------------------
`ifndef DAMPED_SPRING_FORCE_ASSERT_SVH
`define DAMPED_SPRING_FORCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dsf_pkg.sv
// ---------------------------------------------------------------------------
// Damped spring force package
// Types, register indexes, reset values and helpers shared by the datapath.
// ---------------------------------------------------------------------------
package dsf_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int LANES      = 3;

    localparam logic [2:0] REG_STRUCT_KS = 3'd0;
    localparam logic [2:0] REG_STRUCT_KD = 3'd1;
    localparam logic [2:0] REG_SHEAR_KS  = 3'd2;
    localparam logic [2:0] REG_SHEAR_KD  = 3'd3;
    localparam logic [2:0] REG_BEND_KS   = 3'd4;
    localparam logic [2:0] REG_BEND_KD   = 3'd5;

    localparam logic [23:0] RST_STRUCT_KS = 24'd4915200;
    localparam logic [23:0] RST_STRUCT_KD = 24'd32768;
    localparam logic [23:0] RST_SHEAR_KS  = 24'd3276800;
    localparam logic [23:0] RST_SHEAR_KD  = 24'd19661;
    localparam logic [23:0] RST_BEND_KS   = 24'd655360;
    localparam logic [23:0] RST_BEND_KD   = 24'd6554;

    localparam logic [17:0] DIR_MAX = 18'sd65536;
    localparam logic [17:0] DIR_MIN = -18'sd65536;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [30:0]        rest;
        logic [1:0]         kind;
        logic               pa;
        logic               pb;
    } dsf_item_t;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
    } dsf_dir_t;

    typedef struct packed {
        logic [23:0] struct_ks;
        logic [23:0] struct_kd;
        logic [23:0] shear_ks;
        logic [23:0] shear_kd;
        logic [23:0] bend_ks;
        logic [23:0] bend_kd;
    } dsf_cfg_t;

    function automatic logic [31:0] sat32(input logic signed [48:0] v);
        logic [31:0] r;
        if (v > 49'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -49'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/damped_spring_force.sv
// ---------------------------------------------------------------------------
// Damped spring force
// Mass-spring-damper force for one spring per transaction, fixed point.
// ---------------------------------------------------------------------------
// Pipeline: 58 register stages, all of which hold while the output is
// stalled. Throughput: one transaction per cycle while not stalled; the
// 32-stage root pipeline and the divider's 17 quotient steps each retire
// one item a cycle. Reset clears all valid bits and loads the six spring
// constants with their default values.
module damped_spring_force (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] delta_x,
    input  logic [31:0] delta_y,
    input  logic [31:0] delta_z,
    input  logic [31:0] rel_vel_x,
    input  logic [31:0] rel_vel_y,
    input  logic [31:0] rel_vel_z,
    input  logic [30:0] rest_length,
    input  logic [1:0]  spring_kind,
    input  logic        pinned_a,
    input  logic        pinned_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] force_a_x,
    output logic [31:0] force_a_y,
    output logic [31:0] force_a_z,
    output logic [31:0] force_b_x,
    output logic [31:0] force_b_y,
    output logic [31:0] force_b_z,
    output logic        skipped,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import dsf_pkg::*;

    // The whole pipeline moves as one: every stage advances unless the output
    // register holds a result that the consumer is stalling. Bubbles travel
    // with their cleared valid bits, so each stage may hold an item or not.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Configuration registers. Writes to indexes past the last register are
    // simply dropped by the decode.
    dsf_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.struct_ks <= RST_STRUCT_KS;
            cfg_reg.struct_kd <= RST_STRUCT_KD;
            cfg_reg.shear_ks  <= RST_SHEAR_KS;
            cfg_reg.shear_kd  <= RST_SHEAR_KD;
            cfg_reg.bend_ks   <= RST_BEND_KS;
            cfg_reg.bend_kd   <= RST_BEND_KD;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STRUCT_KS: cfg_reg.struct_ks <= cfg_data;
                REG_STRUCT_KD: cfg_reg.struct_kd <= cfg_data;
                REG_SHEAR_KS:  cfg_reg.shear_ks  <= cfg_data;
                REG_SHEAR_KD:  cfg_reg.shear_kd  <= cfg_data;
                REG_BEND_KS:   cfg_reg.bend_ks   <= cfg_data;
                REG_BEND_KD:   cfg_reg.bend_kd   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Gather the input fields into one item that follows the pipeline.
    dsf_item_t in_item;
    assign in_item = '{dx: delta_x, dy: delta_y, dz: delta_z,
                       vx: rel_vel_x, vy: rel_vel_y, vz: rel_vel_z,
                       rest: rest_length, kind: spring_kind,
                       pa: pinned_a, pb: pinned_b};

    // Stage 1 squares each component; stage 2 adds them. The sum of three
    // squares of 32-bit values stays below 2^64, so no bit is lost.
    logic        sq_v_reg;
    logic [63:0] sq_reg [LANES];
    dsf_item_t   sq_item_reg;
    logic        sum_v_reg;
    logic [63:0] sum_reg;
    dsf_item_t   sum_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sq_v_reg  <= 1'b0;
            sum_v_reg <= 1'b0;
        end else if (adv) begin
            sq_v_reg  <= in_valid;
            sum_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            sq_reg[0]    <= $signed(delta_x) * $signed(delta_x);
            sq_reg[1]    <= $signed(delta_y) * $signed(delta_y);
            sq_reg[2]    <= $signed(delta_z) * $signed(delta_z);
            sq_item_reg  <= in_item;
            sum_reg      <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sum_item_reg <= sq_item_reg;
        end
    end

    // Distance as the floor of the square root, in Q16.16.
    logic      rt_valid;
    logic [31:0] rt_dist;
    dsf_item_t rt_item;

    dsf_sqrt_pipe u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (sum_v_reg),
        .in_n     (sum_reg),
        .in_item  (sum_item_reg),
        .out_valid(rt_valid),
        .out_root (rt_dist),
        .out_item (rt_item)
    );

    // An item is skipped when both endpoints are pinned or the endpoints
    // coincide. It still flows through so that every transaction in gives
    // exactly one transaction out, with all forces forced to zero.
    logic rt_skip;
    assign rt_skip = (rt_item.pa && rt_item.pb) || (rt_dist == '0);

    logic      dv_valid;
    logic [31:0] dv_dist;
    logic      dv_skip;
    dsf_dir_t  dv_dir;
    dsf_item_t dv_item;

    dsf_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (rt_valid),
        .in_dist  (rt_dist),
        .in_skip  (rt_skip),
        .in_item  (rt_item),
        .out_valid(dv_valid),
        .out_dist (dv_dist),
        .out_skip (dv_skip),
        .out_dir  (dv_dir),
        .out_item (dv_item)
    );

    // Spring and damper terms, scaling by direction and output saturation.
    // Force B is the saturated negation of the unsaturated force on A.
    dsf_force_pipe u_force (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg_reg),
        .in_valid (dv_valid),
        .in_dist  (dv_dist),
        .in_skip  (dv_skip),
        .in_dir   (dv_dir),
        .in_item  (dv_item),
        .out_valid(out_valid),
        .force_a_x(force_a_x),
        .force_a_y(force_a_y),
        .force_a_z(force_a_z),
        .force_b_x(force_b_x),
        .force_b_y(force_b_y),
        .force_b_z(force_b_z),
        .skipped  (skipped)
    );

endmodule

FILE: hw/rtl/dsf_sqrt_pipe.sv
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit root of a 64-bit value, one result bit per register stage.
// ---------------------------------------------------------------------------
module dsf_sqrt_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [63:0]       in_n,
    input  dsf_pkg::dsf_item_t in_item,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output dsf_pkg::dsf_item_t out_item
);
    import dsf_pkg::*;

    logic        v_reg    [SQRT_STEPS];
    logic [63:0] n_reg    [SQRT_STEPS];
    logic [33:0] rem_reg  [SQRT_STEPS];
    logic [31:0] res_reg  [SQRT_STEPS];
    dsf_item_t   item_reg [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        logic        v_in;
        logic [63:0] n_in;
        logic [33:0] rem_in;
        logic [31:0] res_in;
        dsf_item_t   item_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic        ge;
        logic [33:0] rem_next;
        logic [31:0] res_next;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign n_in    = in_n;
            assign rem_in  = '0;
            assign res_in  = '0;
            assign item_in = in_item;
        end else begin : g_rest
            assign v_in    = v_reg[s-1];
            assign n_in    = n_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign res_in  = res_reg[s-1];
            assign item_in = item_reg[s-1];
        end

        always_comb
        begin
            rem_sh   = {rem_in, n_in[63:62]};
            trial    = {2'b00, res_in, 2'b01};
            ge       = (rem_sh >= trial);
            rem_next = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
            res_next = {res_in[30:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[s] <= 1'b0;
            end else if (adv) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv) begin
                n_reg[s]    <= {n_in[61:0], 2'b00};
                rem_reg[s]  <= rem_next;
                res_reg[s]  <= res_next;
                item_reg[s] <= item_in;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_root  = res_reg[SQRT_STEPS-1];
    assign out_item  = item_reg[SQRT_STEPS-1];

endmodule

FILE: hw/rtl/dsf_div_pipe.sv
// ---------------------------------------------------------------------------
// Pipelined direction divider
// Three restoring dividers compute d * 2^16 / dist, one quotient bit a stage.
// ---------------------------------------------------------------------------
module dsf_div_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [31:0]        in_dist,
    input  logic               in_skip,
    input  dsf_pkg::dsf_item_t in_item,
    output logic               out_valid,
    output logic [31:0]        out_dist,
    output logic               out_skip,
    output dsf_pkg::dsf_dir_t  out_dir,
    output dsf_pkg::dsf_item_t out_item
);
    import dsf_pkg::*;
    `include "damped_spring_force_assert.svh"

    logic        v_reg    [DIV_STEPS];
    logic [31:0] dist_reg [DIV_STEPS];
    logic        skip_reg [DIV_STEPS];
    dsf_item_t   item_reg [DIV_STEPS];
    logic [31:0] rem_reg  [DIV_STEPS][LANES];
    logic [16:0] q_reg    [DIV_STEPS][LANES];

    logic [31:0] abs_d [LANES];
    logic        neg_d [LANES];

    assign neg_d[0] = in_item.dx[31];
    assign neg_d[1] = in_item.dy[31];
    assign neg_d[2] = in_item.dz[31];
    assign abs_d[0] = neg_d[0] ? 32'(-in_item.dx) : in_item.dx;
    assign abs_d[1] = neg_d[1] ? 32'(-in_item.dy) : in_item.dy;
    assign abs_d[2] = neg_d[2] ? 32'(-in_item.dz) : in_item.dz;

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic        v_in;
        logic [31:0] dist_in;
        logic        skip_in;
        dsf_item_t   item_in;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign dist_in = in_dist;
            assign skip_in = in_skip;
            assign item_in = in_item;
        end else begin : g_rest
            assign v_in    = v_reg[s-1];
            assign dist_in = dist_reg[s-1];
            assign skip_in = skip_reg[s-1];
            assign item_in = item_reg[s-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [32:0] cand;
            logic [16:0] q_in;
            logic        ge;
            logic [31:0] rem_next;
            logic [16:0] q_next;

            if (s == 0) begin : g_first
                assign cand = {1'b0, abs_d[l]};
                assign q_in = '0;
            end else begin : g_rest
                assign cand = {rem_reg[s-1][l], 1'b0};
                assign q_in = q_reg[s-1][l];
            end

            always_comb
            begin
                ge       = (cand >= {1'b0, dist_in});
                rem_next = ge ? 32'(cand - {1'b0, dist_in}) : cand[31:0];
                q_next   = {q_in[15:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (adv) begin
                    rem_reg[s][l] <= rem_next;
                    q_reg[s][l]   <= q_next;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[s] <= 1'b0;
            end else if (adv) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv) begin
                dist_reg[s] <= dist_in;
                skip_reg[s] <= skip_in;
                item_reg[s] <= item_in;
            end
        end
    end

    // Apply the sign of each component to its quotient.
    localparam int LAST = DIV_STEPS - 1;

    logic      out_valid_reg;
    dsf_dir_t  dir_reg;
    dsf_dir_t  dir_next;
    logic [31:0] dist_out_reg;
    logic      skip_out_reg;
    dsf_item_t item_out_reg;

    always_comb
    begin
        dir_next.x = item_reg[LAST].dx[31] ? -$signed({1'b0, q_reg[LAST][0]})
                                           :  $signed({1'b0, q_reg[LAST][0]});
        dir_next.y = item_reg[LAST].dy[31] ? -$signed({1'b0, q_reg[LAST][1]})
                                           :  $signed({1'b0, q_reg[LAST][1]});
        dir_next.z = item_reg[LAST].dz[31] ? -$signed({1'b0, q_reg[LAST][2]})
                                           :  $signed({1'b0, q_reg[LAST][2]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            dir_reg      <= dir_next;
            dist_out_reg <= dist_reg[LAST];
            skip_out_reg <= skip_reg[LAST];
            item_out_reg <= item_reg[LAST];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_dir   = dir_reg;
    assign out_dist  = dist_out_reg;
    assign out_skip  = skip_out_reg;
    assign out_item  = item_out_reg;

    // The x and y direction components never exceed the length of the vector.
    `DSF_ASSERT_SAME(a_dir_bound,
        out_valid_reg && dist_out_reg != '0,
        $signed(dir_reg.x) <= $signed(DIR_MAX) && $signed(dir_reg.x) >= $signed(DIR_MIN)
        && $signed(dir_reg.y) <= $signed(DIR_MAX) && $signed(dir_reg.y) >= $signed(DIR_MIN),
        "direction component out of range")
    // A zero z component gives a zero z direction component.
    `DSF_ASSERT_SAME(a_dir_zero,
        out_valid_reg && dist_out_reg != '0 && item_out_reg.dz == '0,
        dir_reg.z == '0,
        "zero component produced a nonzero direction")
    // A valid item in the last divide step reaches the output register.
    `DSF_ASSERT_NEXT(a_div_flow,
        adv && v_reg[LAST],
        out_valid_reg,
        "valid item lost at divider output")

endmodule

FILE: hw/rtl/dsf_force_pipe.sv
// ---------------------------------------------------------------------------
// Spring force back end
// Spring and damper terms, force magnitude, per-axis force and saturation.
// ---------------------------------------------------------------------------
module dsf_force_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  dsf_pkg::dsf_cfg_t  cfg,
    input  logic               in_valid,
    input  logic [31:0]        in_dist,
    input  logic               in_skip,
    input  dsf_pkg::dsf_dir_t  in_dir,
    input  dsf_pkg::dsf_item_t in_item,
    output logic               out_valid,
    output logic [31:0]        force_a_x,
    output logic [31:0]        force_a_y,
    output logic [31:0]        force_a_z,
    output logic [31:0]        force_b_x,
    output logic [31:0]        force_b_y,
    output logic [31:0]        force_b_z,
    output logic               skipped
);
    import dsf_pkg::*;

    // Flags that ride along with each item.
    typedef struct packed {
        logic pa;
        logic pb;
        logic skip;
    } flags_t;

    flags_t in_flags;
    assign in_flags = '{pa: in_item.pa, pb: in_item.pb, skip: in_skip};

    logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    flags_t f1_reg, f2_reg, f3_reg, f4_reg, f5_reg;

    // Stage 1: constant select, spring product, velocity products.
    logic [23:0]        ks_sel;
    logic [23:0]        kd_sel;
    logic signed [33:0] stretch;
    logic signed [58:0] spr_prod_reg;
    logic signed [49:0] dot_p_reg [LANES];
    logic [23:0]        kd1_reg;
    dsf_dir_t           dir1_reg;

    always_comb
    begin
        if (in_item.kind[1]) begin
            ks_sel = cfg.bend_ks;
            kd_sel = cfg.bend_kd;
        end else if (in_item.kind[0]) begin
            ks_sel = cfg.shear_ks;
            kd_sel = cfg.shear_kd;
        end else begin
            ks_sel = cfg.struct_ks;
            kd_sel = cfg.struct_kd;
        end
        stretch = $signed({2'b00, in_dist}) - $signed({3'b000, in_item.rest});
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            spr_prod_reg <= $signed({1'b0, ks_sel}) * stretch;
            dot_p_reg[0] <= $signed(in_item.vx) * in_dir.x;
            dot_p_reg[1] <= $signed(in_item.vy) * in_dir.y;
            dot_p_reg[2] <= $signed(in_item.vz) * in_dir.z;
            kd1_reg      <= kd_sel;
            dir1_reg     <= in_dir;
            f1_reg       <= in_flags;
        end
    end

    // Stage 2: spring term and dot product, both floored to Q16.16.
    logic signed [59:0] spr_neg;
    logic signed [59:0] spr_sh;
    logic signed [51:0] dot_sum;
    logic signed [51:0] dot_sh;
    logic signed [43:0] spr2_reg;
    logic signed [35:0] dot2_reg;
    logic [23:0]        kd2_reg;
    dsf_dir_t           dir2_reg;

    always_comb
    begin
        spr_neg = -(60'(spr_prod_reg));
        spr_sh  = spr_neg >>> 16;
        dot_sum = 52'(dot_p_reg[0]) + 52'(dot_p_reg[1]) + 52'(dot_p_reg[2]);
        dot_sh  = dot_sum >>> 16;
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            spr2_reg <= spr_sh[43:0];
            dot2_reg <= dot_sh[35:0];
            kd2_reg  <= kd1_reg;
            dir2_reg <= dir1_reg;
            f2_reg   <= f1_reg;
        end
    end

    // Stage 3: damper product.
    logic signed [60:0] dmp_prod_reg;
    logic signed [43:0] spr3_reg;
    dsf_dir_t           dir3_reg;

    always_ff @(posedge clk)
    begin
        if (adv) begin
            dmp_prod_reg <= $signed({1'b0, kd2_reg}) * dot2_reg;
            spr3_reg     <= spr2_reg;
            dir3_reg     <= dir2_reg;
            f3_reg       <= f2_reg;
        end
    end

    // Stage 4: force magnitude.
    logic signed [60:0] dmp_sh;
    logic signed [44:0] dmp_val;
    logic signed [45:0] mag_reg;
    dsf_dir_t           dir4_reg;

    always_comb
    begin
        dmp_sh  = dmp_prod_reg >>> 16;
        dmp_val = dmp_sh[44:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            mag_reg  <= 46'(spr3_reg) + 46'(dmp_val);
            dir4_reg <= dir3_reg;
            f4_reg   <= f3_reg;
        end
    end

    // Stage 5: per-axis force products.
    logic signed [63:0] fa_p_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (adv) begin
            fa_p_reg[0] <= mag_reg * dir4_reg.x;
            fa_p_reg[1] <= mag_reg * dir4_reg.y;
            fa_p_reg[2] <= mag_reg * dir4_reg.z;
            f5_reg      <= f4_reg;
        end
    end

    // Stage 6: floor, saturate, mask pinned endpoints and skipped items.
    logic signed [63:0] fa_sh  [LANES];
    logic signed [48:0] fa_w   [LANES];
    logic [31:0]        fa_sat [LANES];
    logic [31:0]        fb_sat [LANES];
    logic               a_on;
    logic               b_on;
    logic [31:0]        fa_reg [LANES];
    logic [31:0]        fb_reg [LANES];
    logic               skip6_reg;

    always_comb
    begin
        a_on = !f5_reg.skip && !f5_reg.pa;
        b_on = !f5_reg.skip && !f5_reg.pb;
        for (int l = 0; l < LANES; l++) begin
            fa_sh[l]  = fa_p_reg[l] >>> 16;
            fa_w[l]   = fa_sh[l][48:0];
            fa_sat[l] = a_on ? sat32(fa_w[l]) : '0;
            fb_sat[l] = b_on ? sat32(-fa_w[l]) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            fa_reg    <= fa_sat;
            fb_reg    <= fb_sat;
            skip6_reg <= f5_reg.skip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign force_a_x = fa_reg[0];
    assign force_a_y = fa_reg[1];
    assign force_a_z = fa_reg[2];
    assign force_b_x = fb_reg[0];
    assign force_b_y = fb_reg[1];
    assign force_b_z = fb_reg[2];
    assign skipped   = skip6_reg;

endmodule
